/* src/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge out of reset
`define ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition never occurs out of reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

/* src/mie_pkg.sv */
// ----------------------------------------------------------------------------
// mie_pkg
// Types and codes shared by the I-type execute unit.
// ----------------------------------------------------------------------------
package mie_pkg;

  // Operation codes carried on the input tuser
  typedef enum logic [4:0] {
    KIND_BEQ    = 5'd0,
    KIND_BNE    = 5'd1,
    KIND_BLEZ   = 5'd2,
    KIND_BGTZ   = 5'd3,
    KIND_BLTZ   = 5'd4,
    KIND_BLTZAL = 5'd5,
    KIND_BGEZ   = 5'd6,
    KIND_BGEZAL = 5'd7,
    KIND_ADDI   = 5'd8,
    KIND_ADDIU  = 5'd9,
    KIND_SLTI   = 5'd10,
    KIND_SLTIU  = 5'd11,
    KIND_ANDI   = 5'd12,
    KIND_ORI    = 5'd13,
    KIND_XORI   = 5'd14,
    KIND_LUI    = 5'd15,
    KIND_LB     = 5'd16,
    KIND_LH     = 5'd17,
    KIND_LBU    = 5'd18,
    KIND_LHU    = 5'd19,
    KIND_SB     = 5'd20,
    KIND_SH     = 5'd21,
    KIND_SW     = 5'd22,
    KIND_LW     = 5'd23,
    KIND_LWL    = 5'd24,
    KIND_LWR    = 5'd25
  } kind_e;

  // Memory access kind
  typedef enum logic [1:0] {
    ACC_NONE  = 2'd0,
    ACC_READ  = 2'd1,
    ACC_WRITE = 2'd2
  } access_e;

  // Access size
  typedef enum logic [1:0] {
    SIZE_BYTE = 2'd0,
    SIZE_HALF = 2'd1,
    SIZE_WORD = 2'd2
  } size_e;

  localparam int unsigned InDataW  = 144;
  localparam int unsigned OutDataW = 128;
  localparam int unsigned KindW    = 5;

  // One instruction as registered at the input
  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] source_value;
    logic [31:0] target_value;
    logic [15:0] immediate;
    logic [31:0] program_counter;
    logic [31:0] memory_data;
  } item_t;

  // One execute result
  typedef struct packed {
    logic               write_enable;
    logic [31:0]        write_value;
    logic               link_write;
    logic               branch_taken;
    logic signed [17:0] branch_offset;
    access_e            memory_access;
    size_e              access_size;
    logic [31:0]        memory_address;
    logic [31:0]        store_value;
    logic               overflow;
  } res_t;

endpackage

/* src/mie_execute.sv */
// ----------------------------------------------------------------------------
// mie_execute
// Single-pass datapath: ALU-immediate ops, branch compare, address and
// store data generation, load extension and lwl/lwr merge.
// ----------------------------------------------------------------------------
module mie_execute (
  input  mie_pkg::item_t item_i,
  output mie_pkg::res_t  res_o
);
  import mie_pkg::*;

  logic [31:0] rs;
  logic [31:0] rt;
  logic [31:0] md;
  logic [31:0] simm;
  logic [31:0] zimm;
  logic [31:0] addr;
  logic [31:0] addr_word;
  logic [1:0]  off;
  logic        neg;
  logic        rs_zero;

  // Common operand preparation
  assign rs        = item_i.source_value;
  assign rt        = item_i.target_value;
  assign md        = item_i.memory_data;
  assign simm      = {{16{item_i.immediate[15]}}, item_i.immediate};
  assign zimm      = {16'h0000, item_i.immediate};
  assign addr      = rs + simm;
  assign addr_word = {addr[31:2], 2'b00};
  assign off       = addr[1:0];
  assign neg       = rs[31];
  assign rs_zero   = (rs == 32'h0000_0000);

  // Decode and compute
  always_comb begin
    res_o = '0;
    res_o.memory_access = ACC_NONE;
    res_o.access_size   = SIZE_BYTE;
    unique case (kind_e'(item_i.kind))
      KIND_BEQ, KIND_BNE, KIND_BLEZ, KIND_BGTZ,
      KIND_BLTZ, KIND_BLTZAL, KIND_BGEZ, KIND_BGEZAL: begin
        res_o.branch_offset = {item_i.immediate, 2'b00};
        unique case (kind_e'(item_i.kind))
          KIND_BEQ:               res_o.branch_taken = (rs == rt);
          KIND_BNE:               res_o.branch_taken = (rs != rt);
          KIND_BLEZ:              res_o.branch_taken = neg | rs_zero;
          KIND_BGTZ:              res_o.branch_taken = ~neg & ~rs_zero;
          KIND_BLTZ, KIND_BLTZAL: res_o.branch_taken = neg;
          default:                res_o.branch_taken = ~neg;
        endcase
        // Linking branches write PC+8 to r31 taken or not
        if (kind_e'(item_i.kind) == KIND_BLTZAL || kind_e'(item_i.kind) == KIND_BGEZAL) begin
          res_o.write_enable = 1'b1;
          res_o.link_write   = 1'b1;
          res_o.write_value  = item_i.program_counter + 32'd8;
        end
      end
      KIND_ADDI: begin
        // Suppress the write on signed overflow
        if ((rs[31] == simm[31]) && (addr[31] != rs[31])) begin
          res_o.overflow = 1'b1;
        end else begin
          res_o.write_enable = 1'b1;
          res_o.write_value  = addr;
        end
      end
      KIND_ADDIU: begin
        res_o.write_enable = 1'b1;
        res_o.write_value  = addr;
      end
      KIND_SLTI: begin
        res_o.write_enable = 1'b1;
        res_o.write_value  = {31'd0, ($signed(rs) < $signed(simm))};
      end
      KIND_SLTIU: begin
        res_o.write_enable = 1'b1;
        res_o.write_value  = {31'd0, (rs < simm)};
      end
      KIND_ANDI: begin
        res_o.write_enable = 1'b1;
        res_o.write_value  = rs & zimm;
      end
      KIND_ORI: begin
        res_o.write_enable = 1'b1;
        res_o.write_value  = rs | zimm;
      end
      KIND_XORI: begin
        res_o.write_enable = 1'b1;
        res_o.write_value  = rs ^ zimm;
      end
      KIND_LUI: begin
        res_o.write_enable = 1'b1;
        res_o.write_value  = {item_i.immediate, 16'h0000};
      end
      KIND_SB, KIND_SH, KIND_SW: begin
        res_o.memory_access  = ACC_WRITE;
        res_o.memory_address = addr;
        unique case (kind_e'(item_i.kind))
          KIND_SB: begin
            res_o.access_size = SIZE_BYTE;
            res_o.store_value = {24'd0, rt[7:0]};
          end
          KIND_SH: begin
            res_o.access_size = SIZE_HALF;
            res_o.store_value = {16'd0, rt[15:0]};
          end
          default: begin
            res_o.access_size = SIZE_WORD;
            res_o.store_value = rt;
          end
        endcase
      end
      KIND_LB, KIND_LH, KIND_LBU, KIND_LHU, KIND_LW, KIND_LWL, KIND_LWR: begin
        res_o.memory_access  = ACC_READ;
        res_o.write_enable   = 1'b1;
        res_o.memory_address = addr;
        unique case (kind_e'(item_i.kind))
          KIND_LB: begin
            res_o.access_size = SIZE_BYTE;
            res_o.write_value = {{24{md[7]}}, md[7:0]};
          end
          KIND_LH: begin
            res_o.access_size = SIZE_HALF;
            res_o.write_value = {{16{md[15]}}, md[15:0]};
          end
          KIND_LBU: begin
            res_o.access_size = SIZE_BYTE;
            res_o.write_value = {24'd0, md[7:0]};
          end
          KIND_LHU: begin
            res_o.access_size = SIZE_HALF;
            res_o.write_value = {16'd0, md[15:0]};
          end
          KIND_LW: begin
            res_o.access_size = SIZE_WORD;
            res_o.write_value = md;
          end
          KIND_LWL: begin
            // Merge the low-order bytes of the aligned word into the high end of rt
            res_o.access_size    = SIZE_WORD;
            res_o.memory_address = addr_word;
            unique case (off)
              2'd0:    res_o.write_value = md;
              2'd1:    res_o.write_value = {md[23:0], rt[7:0]};
              2'd2:    res_o.write_value = {md[15:0], rt[15:0]};
              default: res_o.write_value = {md[7:0], rt[23:0]};
            endcase
          end
          default: begin
            // Merge the high-order bytes of the aligned word into the low end of rt
            res_o.access_size    = SIZE_WORD;
            res_o.memory_address = addr_word;
            unique case (off)
              2'd0:    res_o.write_value = {rt[31:8], md[31:24]};
              2'd1:    res_o.write_value = {rt[31:16], md[31:16]};
              2'd2:    res_o.write_value = {rt[31:24], md[31:8]};
              default: res_o.write_value = md;
            endcase
          end
        endcase
      end
      default: begin
        // Unused codes leave every field at zero
        res_o = '0;
      end
    endcase
  end

endmodule

/* src/mips_itype_execute.sv */
// ----------------------------------------------------------------------------
// mips_itype_execute
// MIPS32 I-type execute unit with registered input and output beats.
// ----------------------------------------------------------------------------
// Usage:
//   One input beat carries one I-type instruction: the operation code on
//   s_axis_tuser, the rs/rt values, immediate, PC and loaded data on
//   s_axis_tdata. One output beat carries its result: write enable and
//   value, link flag, branch decision and offset, memory access kind, size,
//   address and store data, and the addi overflow flag.
//   Path: an accepted beat passes the input register and then the result
//   register before it appears on m_axis_tvalid.
//   Throughput: one instruction per cycle, sustained while m_axis_tready is
//   high; the whole calculation sits between the two registers.
//   Stall: when the receiver holds m_axis_tready low the result register
//   holds its beat and the input register still takes one more beat; after
//   that s_axis_tready drops until the result is taken.
//   Reset: both stages empty, s_axis_tready high, m_axis_tvalid low.
// ----------------------------------------------------------------------------
module mips_itype_execute (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // tuser: kind[4:0]
  input  logic [mie_pkg::KindW-1:0]     s_axis_tuser,
  // tdata: source_value[31:0], target_value[63:32], immediate[79:64],
  //        program_counter[111:80], memory_data[143:112]
  input  logic [mie_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: write_enable[0], write_value[32:1], link_write[33],
  //        branch_taken[34], branch_offset[52:35], memory_access[54:53],
  //        access_size[56:55], memory_address[88:57], store_value[120:89],
  //        overflow[121], zero pad [127:122]
  output logic [mie_pkg::OutDataW-1:0]  m_axis_tdata
);
  import mie_pkg::*;

  logic  in_vld_q;
  item_t in_q;
  logic  out_vld_q;
  res_t  res_d;
  res_t  res_q;
  logic  in_take;
  logic  advance;

  // Move the held instruction forward when the result slot is free or its beat is being taken
  assign advance       = in_vld_q & (~out_vld_q | m_axis_tready);
  assign s_axis_tready = ~in_vld_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  // Input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q.kind            <= s_axis_tuser;
      in_q.source_value    <= s_axis_tdata[31:0];
      in_q.target_value    <= s_axis_tdata[63:32];
      in_q.immediate       <= s_axis_tdata[79:64];
      in_q.program_counter <= s_axis_tdata[111:80];
      in_q.memory_data     <= s_axis_tdata[143:112];
    end
  end

  mie_execute u_execute (
    .item_i (in_q),
    .res_o  (res_d)
  );

  // Result stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Result stage payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // Pack the result beat
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'd0,
                          res_q.overflow,
                          res_q.store_value,
                          res_q.memory_address,
                          res_q.access_size,
                          res_q.memory_access,
                          res_q.branch_offset,
                          res_q.branch_taken,
                          res_q.link_write,
                          res_q.write_value,
                          res_q.write_enable};

`include "assert_macros.svh"

  `ASSERT_NEVER(a_ovf_no_write, out_vld_q && res_q.overflow && res_q.write_enable, "overflow with write enabled")
  `ASSERT_HOLDS(a_link_writes, (out_vld_q && res_q.link_write) |-> res_q.write_enable, "link without write")
  `ASSERT_HOLDS(a_no_acc_no_addr, (out_vld_q && res_q.memory_access == ACC_NONE) |-> (res_q.memory_address == 32'd0 && res_q.access_size == SIZE_BYTE && res_q.store_value == 32'd0), "address or size without access")
  `ASSERT_HOLDS(a_out_from_in, $rose(out_vld_q) |-> $past(in_vld_q), "result without held instruction")

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the MIPS I-type execute unit. Instructions go in as
// stream beats. A scoreboard class predicts each result from the instruction
// and compares every field of the output beats in order, with random gaps
// on the input side and random stalls on the output side.
// ----------------------------------------------------------------------------
module testbench;
  import mie_pkg::*;

  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned MaxReports   = 10;
  localparam int unsigned NumKinds     = 26;
  localparam int unsigned PhaseBeats   = 160;
  localparam int unsigned SettleCycles = 8;

  // Predict execute results and check output beats against them
  class execute_scoreboard;
    res_t        pending_results[$];
    int unsigned mismatches;
    int unsigned results_checked;

    function res_t predict_execute(logic [4:0] kind, logic [31:0] rs, logic [31:0] rt,
                                   logic [15:0] imm, logic [31:0] pc, logic [31:0] md);
      res_t        r;
      logic [31:0] simm;
      logic [31:0] addr;
      logic [31:0] sum;
      logic [1:0]  byte_off;
      r        = '0;
      simm     = {{16{imm[15]}}, imm};
      addr     = rs + simm;
      sum      = rs + simm;
      byte_off = addr[1:0];
      // Branches carry the word offset whatever the outcome
      if (kind <= KIND_BGEZAL) begin
        r.branch_offset = {imm, 2'b00};
      end
      case (kind)
        KIND_BEQ:  r.branch_taken = (rs == rt);
        KIND_BNE:  r.branch_taken = (rs != rt);
        KIND_BLEZ: r.branch_taken = rs[31] || (rs == '0);
        KIND_BGTZ: r.branch_taken = !rs[31] && (rs != '0);
        KIND_BLTZ: r.branch_taken = rs[31];
        KIND_BGEZ: r.branch_taken = !rs[31];
        KIND_BLTZAL, KIND_BGEZAL: begin
          // Linking branches write PC+8 to r31 even when not taken
          r.branch_taken = (kind == KIND_BLTZAL) ? rs[31] : !rs[31];
          r.write_enable = 1'b1;
          r.link_write   = 1'b1;
          r.write_value  = pc + 32'd8;
        end
        KIND_ADDI: begin
          if (((rs ^ sum) & (simm ^ sum)) >> 31) begin
            r.overflow = 1'b1;
          end else begin
            r.write_enable = 1'b1;
            r.write_value  = sum;
          end
        end
        KIND_ADDIU, KIND_SLTI, KIND_SLTIU, KIND_ANDI, KIND_ORI, KIND_XORI, KIND_LUI: begin
          r.write_enable = 1'b1;
          case (kind)
            KIND_ADDIU: r.write_value = sum;
            KIND_SLTI:  r.write_value = {31'd0, $signed(rs) < $signed(simm)};
            KIND_SLTIU: r.write_value = {31'd0, rs < simm};
            KIND_ANDI:  r.write_value = rs & {16'd0, imm};
            KIND_ORI:   r.write_value = rs | {16'd0, imm};
            KIND_XORI:  r.write_value = rs ^ {16'd0, imm};
            default:    r.write_value = {imm, 16'd0};
          endcase
        end
        KIND_SB, KIND_SH, KIND_SW: begin
          r.memory_access  = ACC_WRITE;
          r.memory_address = addr;
          case (kind)
            KIND_SB: begin
              r.access_size = SIZE_BYTE;
              r.store_value = {24'd0, rt[7:0]};
            end
            KIND_SH: begin
              r.access_size = SIZE_HALF;
              r.store_value = {16'd0, rt[15:0]};
            end
            default: begin
              r.access_size = SIZE_WORD;
              r.store_value = rt;
            end
          endcase
        end
        KIND_LB, KIND_LH, KIND_LBU, KIND_LHU, KIND_LW, KIND_LWL, KIND_LWR: begin
          r.memory_access  = ACC_READ;
          r.write_enable   = 1'b1;
          r.memory_address = addr;
          r.access_size    = SIZE_WORD;
          case (kind)
            KIND_LB: begin
              r.access_size = SIZE_BYTE;
              r.write_value = {{24{md[7]}}, md[7:0]};
            end
            KIND_LH: begin
              r.access_size = SIZE_HALF;
              r.write_value = {{16{md[15]}}, md[15:0]};
            end
            KIND_LBU: begin
              r.access_size = SIZE_BYTE;
              r.write_value = {24'd0, md[7:0]};
            end
            KIND_LHU: begin
              r.access_size = SIZE_HALF;
              r.write_value = {16'd0, md[15:0]};
            end
            KIND_LW: r.write_value = md;
            KIND_LWL: begin
              // Merge the low-order end of the aligned word into the high end of rt, big-endian
              r.memory_address = {addr[31:2], 2'b00};
              case (byte_off)
                2'd0:    r.write_value = md;
                2'd1:    r.write_value = {md[23:0], rt[7:0]};
                2'd2:    r.write_value = {md[15:0], rt[15:0]};
                default: r.write_value = {md[7:0], rt[23:0]};
              endcase
            end
            default: begin
              // Merge the high-order end of the aligned word into the low end of rt, big-endian
              r.memory_address = {addr[31:2], 2'b00};
              case (byte_off)
                2'd0:    r.write_value = {rt[31:8], md[31:24]};
                2'd1:    r.write_value = {rt[31:16], md[31:16]};
                2'd2:    r.write_value = {rt[31:24], md[31:8]};
                default: r.write_value = md;
              endcase
            end
          endcase
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_instruction(logic [4:0] kind, logic [31:0] rs, logic [31:0] rt,
                                   logic [15:0] imm, logic [31:0] pc, logic [31:0] md);
      pending_results.push_back(predict_execute(kind, rs, rt, imm, pc, md));
    endfunction

    function void flag_field(string field_name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("[%0t] result %0d %s: expected %h, got %h",
                   $time, results_checked, field_name, exp_v, act_v);
        end
      end
    endfunction

    function void check_result(logic [127:0] beat);
      res_t got;
      res_t want;
      got.write_enable   = beat[0];
      got.write_value    = beat[32:1];
      got.link_write     = beat[33];
      got.branch_taken   = beat[34];
      got.branch_offset  = beat[52:35];
      got.memory_access  = access_e'(beat[54:53]);
      got.access_size    = size_e'(beat[56:55]);
      got.memory_address = beat[88:57];
      got.store_value    = beat[120:89];
      got.overflow       = beat[121];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("[%0t] result beat with no instruction pending: %h", $time, beat);
        end
        return;
      end
      want = pending_results.pop_front();
      flag_field("write_enable", 32'(want.write_enable), 32'(got.write_enable));
      flag_field("write_value", want.write_value, got.write_value);
      flag_field("link_write", 32'(want.link_write), 32'(got.link_write));
      flag_field("branch_taken", 32'(want.branch_taken), 32'(got.branch_taken));
      flag_field("branch_offset", 32'(want.branch_offset), 32'(got.branch_offset));
      flag_field("memory_access", 32'(want.memory_access), 32'(got.memory_access));
      flag_field("access_size", 32'(want.access_size), 32'(got.access_size));
      flag_field("memory_address", want.memory_address, got.memory_address);
      flag_field("store_value", want.store_value, got.store_value);
      flag_field("overflow", 32'(want.overflow), 32'(got.overflow));
      results_checked++;
    endfunction
  endclass

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // tuser: kind[4:0]
  logic [4:0]   s_axis_tuser;
  // tdata: source_value, target_value, immediate, program_counter, memory_data
  logic [143:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // tdata: write_enable, write_value, link_write, branch_taken, branch_offset,
  //        memory_access, access_size, memory_address, store_value, overflow
  logic [127:0] m_axis_tdata;

  execute_scoreboard sb;
  int unsigned       send_idle_pct;
  int unsigned       recv_stall_pct;
  int unsigned       cycle_count;
  int unsigned       beats_sent;
  bit                kind_seen [NumKinds];

  mips_itype_execute i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 50 MHz clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Watchdog on total run length
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("mips_itype_execute verification failed");
      $finish;
    end
  end

  // Record accepted instructions and check accepted results
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_instruction(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32],
                            s_axis_tdata[79:64], s_axis_tdata[111:80],
                            s_axis_tdata[143:112]);
        beats_sent++;
        if (s_axis_tuser < NumKinds) begin
          kind_seen[s_axis_tuser] = 1'b1;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata);
      end
    end
  end

  // Receiver backpressure
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Drive one instruction beat and hold it until accepted
  task automatic send_instruction(input logic [4:0] kind, input logic [31:0] rs,
                                  input logic [31:0] rt, input logic [15:0] imm,
                                  input logic [31:0] pc, input logic [31:0] md);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tuser  = kind;
    s_axis_tdata  = {md, pc, imm, rt, rs};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Drop valid and hold off until every pending result has come back
  task automatic drain_pipeline();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_half();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random instructions of every kind, rt sometimes equal to rs for beq/bne
  task automatic send_random(input int unsigned count);
    logic [31:0] rs;
    logic [31:0] rt;
    for (int unsigned n = 0; n < count; n++) begin
      rs = pick_word();
      rt = ($urandom_range(0, 3) == 0) ? rs : pick_word();
      send_instruction(5'($urandom_range(0, NumKinds - 1)), rs, rt, pick_half(),
                       pick_word(), pick_word());
    end
  endtask

  initial begin
    int unsigned kinds_covered;
    sb             = new();
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    s_axis_tvalid  = 1'b0;
    s_axis_tuser   = '0;
    s_axis_tdata   = '0;
    m_axis_tready  = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    cycle_count    = 0;
    beats_sent     = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every operation, corner cases
    send_instruction(KIND_BEQ, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0001, 32'h0, 32'h0);
    send_instruction(KIND_BNE, 32'h1234_5678, 32'h1234_5678, 16'h8000, 32'h0, 32'h0);
    send_instruction(KIND_BLEZ, 32'h0, 32'h0, 16'hFFFF, 32'h0, 32'h0);
    send_instruction(KIND_BGTZ, 32'h7FFF_FFFF, 32'h0, 16'h7FFF, 32'h0, 32'h0);
    send_instruction(KIND_BLTZ, 32'h8000_0000, 32'h0, 16'h0000, 32'h0, 32'h0);
    // link is written even when not taken; PC+8 wraps
    send_instruction(KIND_BLTZAL, 32'h0, 32'h0, 16'h0004, 32'hFFFF_FFFC, 32'h0);
    send_instruction(KIND_BGEZ, 32'hFFFF_FFFF, 32'h0, 16'hFFFC, 32'h0, 32'h0);
    send_instruction(KIND_BGEZAL, 32'h0, 32'h0, 16'h0010, 32'h0040_0000, 32'h0);
    // addi overflow both ways suppresses the write
    send_instruction(KIND_ADDI, 32'h7FFF_FFFF, 32'h0, 16'h0001, 32'h0, 32'h0);
    send_instruction(KIND_ADDI, 32'h8000_0000, 32'h0, 16'hFFFF, 32'h0, 32'h0);
    send_instruction(KIND_ADDI, 32'h8000_0000, 32'h0, 16'h7FFF, 32'h0, 32'h0);
    send_instruction(KIND_ADDIU, 32'hFFFF_FFFF, 32'h0, 16'h0001, 32'h0, 32'h0);
    send_instruction(KIND_SLTI, 32'h8000_0000, 32'h0, 16'h0000, 32'h0, 32'h0);
    send_instruction(KIND_SLTIU, 32'h0000_0001, 32'h0, 16'hFFFF, 32'h0, 32'h0);
    send_instruction(KIND_ANDI, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 32'h0, 32'h0);
    send_instruction(KIND_ORI, 32'h0, 32'h0, 16'hFFFF, 32'h0, 32'h0);
    send_instruction(KIND_XORI, 32'hFFFF_FFFF, 32'h0, 16'hAAAA, 32'h0, 32'h0);
    send_instruction(KIND_LUI, 32'h0, 32'h0, 16'hFFFF, 32'h0, 32'h0);
    send_instruction(KIND_LB, 32'h1000_0000, 32'h0, 16'h8000, 32'h0, 32'hFFFF_FF80);
    send_instruction(KIND_LH, 32'h1000_0000, 32'h0, 16'h0003, 32'h0000_8000, 32'h0000_8000);
    send_instruction(KIND_LBU, 32'h0, 32'h0, 16'h0000, 32'h0, 32'hFFFF_FFFF);
    send_instruction(KIND_LHU, 32'h0, 32'h0, 16'h0001, 32'h0, 32'hFFFF_FFFF);
    // store address wraps past the top of memory
    send_instruction(KIND_SB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h0002, 32'h0, 32'h0);
    send_instruction(KIND_SH, 32'h0000_0001, 32'hFFFF_FFFF, 16'hFFFF, 32'h0, 32'h0);
    send_instruction(KIND_SW, 32'h8000_0000, 32'hDEAD_BEEF, 16'h7FFF, 32'h0, 32'h0);
    send_instruction(KIND_LW, 32'h0000_1002, 32'h0, 16'h0001, 32'h0, 32'h8000_0001);
    send_instruction(KIND_LWL, 32'h0000_2000, 32'h1122_3344, 16'h0003, 32'h0, 32'hAABB_CCDD);
    send_instruction(KIND_LWR, 32'h0000_2000, 32'h1122_3344, 16'h0001, 32'h0, 32'hAABB_CCDD);
    drain_pipeline();

    // Random phases with varying gaps and backpressure
    send_idle_pct = 0;  recv_stall_pct = 0;
    send_random(PhaseBeats);
    drain_pipeline();
    send_idle_pct = 56; recv_stall_pct = 0;
    send_random(PhaseBeats);
    drain_pipeline();
    send_idle_pct = 0;  recv_stall_pct = 56;
    send_random(PhaseBeats);
    drain_pipeline();
    send_idle_pct = 37; recv_stall_pct = 37;
    send_random(PhaseBeats);
    drain_pipeline();

    // Let any stray beat show up before the verdict
    repeat (SettleCycles) @(posedge clk_i);
    kinds_covered = 0;
    foreach (kind_seen[k]) kinds_covered += 32'(kind_seen[k]);
    $display("Sent %0d instructions covering %0d of %0d operation kinds in %0d cycles.",
             beats_sent, kinds_covered, NumKinds, cycle_count);
    $display("Checked %0d results field by field, %0d field mismatches, %0d left pending.",
             sb.results_checked, sb.mismatches, sb.pending_results.size());
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("mips_itype_execute verification clean");
    end else begin
      $display("mips_itype_execute verification failed");
    end
    $finish;
  end

endmodule
